### sv/fntsn_pkg.sv
// ----------------------------------------------------------------------------
// fntsn_pkg : shared types, constants and helpers for the 8.3 short-name builder
// Holds the short-name geometry, the illegal base character set and the
// character helpers used by the builder.
// ----------------------------------------------------------------------------
package fntsn_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] pos_t;

    localparam int    SFN_LEN       = 11;
    localparam int    BASE_LEN      = 8;
    localparam int    ILLEGAL_COUNT = 16;
    localparam pos_t  SFN_LAST      = pos_t'(SFN_LEN - 1);
    localparam pos_t  BASE_END      = pos_t'(BASE_LEN);
    localparam pos_t  SFN_END       = pos_t'(SFN_LEN);
    localparam byte_t PAD_CHAR      = 8'h20;
    localparam byte_t DOT_CHAR      = 8'h2E;
    localparam byte_t CASE_GAP      = 8'd32;
    localparam byte_t LOWER_A       = 8'h61;
    localparam byte_t LOWER_Z       = 8'h7A;

    typedef byte_t sfn_buf_t [SFN_LEN];

    localparam byte_t ILLEGAL_SET [ILLEGAL_COUNT] = '{
        8'h22, 8'h2A, 8'h2B, 8'h2C, 8'h2E, 8'h2F, 8'h3A, 8'h3B,
        8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h5B, 8'h5C, 8'h5D, 8'h7C
    };

    function automatic byte_t make_upper(input byte_t c);
        byte_t r;
        r = c;
        if (c >= LOWER_A && c <= LOWER_Z)
        begin
            r = c - CASE_GAP;
        end
        return r;
    endfunction

    function automatic logic base_char_legal(input byte_t c);
        logic ok;
        ok = (c > PAD_CHAR);
        for (int k = 0; k < ILLEGAL_COUNT; k++)
        begin
            if (c == ILLEGAL_SET[k])
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

### sv/file_name_to_short_name.sv
// ----------------------------------------------------------------------------
// file_name_to_short_name : FAT 8.3 short-name builder
// Name bytes enter one per item on the char channel, the final byte flagged by
// last_char. Each byte is folded into the short-name buffer in the cycle it is
// accepted, so a name byte is taken every cycle unless a final byte stalls. When
// the flagged byte is taken, the finished 11-byte space-padded name and its
// verdict move to an output shift register and leave on the sfn channel over 11
// items, the last one flagged by last_byte, while the next name is already
// being collected. A final byte of the next name stalls only while the previous
// name is still leaving; the one-byte-per-cycle output shifter advances only
// while sfn_stall is low.
// ----------------------------------------------------------------------------
module file_name_to_short_name
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_stall,
    input  fntsn_pkg::byte_t  name_char,
    input  logic              last_char,
    output logic              sfn_valid,
    input  logic              sfn_stall,
    output fntsn_pkg::byte_t  short_byte,
    output logic              name_valid,
    output logic              last_byte
);
    import fntsn_pkg::*;

    sfn_buf_t buf_reg;
    sfn_buf_t buf_next;
    pos_t     fill_reg;
    pos_t     fill_next;
    logic     ext_reg;
    logic     ext_next;
    logic     rej_reg;
    logic     rej_next;

    sfn_buf_t out_buf_reg;
    logic     out_ok_reg;
    logic     busy_reg;
    pos_t     count_reg;

    logic     in_take;
    logic     out_take;
    logic     finishing;

    assign out_take   = busy_reg && !sfn_stall;
    assign finishing  = out_take && (count_reg == SFN_LAST);
    assign char_stall = last_char && busy_reg && !finishing;
    assign in_take    = char_valid && !char_stall;

    assign sfn_valid  = busy_reg;
    assign short_byte = out_buf_reg[0];
    assign name_valid = out_ok_reg;
    assign last_byte  = (count_reg == SFN_LAST);

    always_comb
    begin
        buf_next  = buf_reg;
        fill_next = fill_reg;
        ext_next  = ext_reg;
        rej_next  = rej_reg;
        if (!rej_reg)
        begin
            if (!ext_reg)
            begin
                if (name_char == DOT_CHAR)
                begin
                    ext_next  = 1'b1;
                    fill_next = BASE_END;
                end
                else if (fill_reg >= BASE_END || !base_char_legal(name_char))
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    buf_next[fill_reg] = make_upper(name_char);
                    fill_next          = fill_reg + pos_t'(1);
                end
            end
            else
            begin
                if (fill_reg >= SFN_END)
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    buf_next[fill_reg] = make_upper(name_char);
                    fill_next          = fill_reg + pos_t'(1);
                end
            end
        end
    end

    // collect the name being received
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SFN_LEN; k++)
            begin
                buf_reg[k] <= PAD_CHAR;
            end
            fill_reg <= '0;
            ext_reg  <= 1'b0;
            rej_reg  <= 1'b0;
        end
        else if (in_take)
        begin
            if (last_char)
            begin
                for (int k = 0; k < SFN_LEN; k++)
                begin
                    buf_reg[k] <= PAD_CHAR;
                end
                fill_reg <= '0;
                ext_reg  <= 1'b0;
                rej_reg  <= 1'b0;
            end
            else
            begin
                buf_reg  <= buf_next;
                fill_reg <= fill_next;
                ext_reg  <= ext_next;
                rej_reg  <= rej_next;
            end
        end
    end

    // control of the output shifter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (in_take && last_char)
        begin
            busy_reg  <= 1'b1;
            count_reg <= '0;
        end
        else if (out_take)
        begin
            if (count_reg == SFN_LAST)
            begin
                busy_reg  <= 1'b0;
                count_reg <= '0;
            end
            else
            begin
                count_reg <= count_reg + pos_t'(1);
            end
        end
    end

    // load a finished name, or advance by one byte
    always_ff @(posedge clk)
    begin
        if (in_take && last_char)
        begin
            out_buf_reg <= buf_next;
            out_ok_reg  <= !rej_next;
        end
        else if (out_take)
        begin
            for (int k = 0; k < SFN_LEN - 1; k++)
            begin
                out_buf_reg[k] <= out_buf_reg[k + 1];
            end
            out_buf_reg[SFN_LEN - 1] <= PAD_CHAR;
        end
    end

    a_last_only_when_free : assert property (@(posedge clk) disable iff (!rst_n)
        in_take && last_char && busy_reg |-> finishing)
        else $error("final name item taken while previous name still leaving");

    a_load_starts_output : assert property (@(posedge clk) disable iff (!rst_n)
        in_take && last_char |=> sfn_valid && count_reg == '0)
        else $error("finished name did not start the output");

    a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SFN_LAST && (busy_reg || count_reg == '0))
        else $error("output count out of range");

    a_fill_range : assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= SFN_END && (ext_reg || fill_reg <= BASE_END))
        else $error("fill position out of range");

    a_output_ends : assert property (@(posedge clk) disable iff (!rst_n)
        finishing && !(in_take && last_char) |=> !sfn_valid)
        else $error("output ran past the eleventh item");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : self-checking bench for the FAT 8.3 short-name builder
// Streams file names into the block one byte per item and checks every byte of
// each 11-byte short name against a predictor of the builder kept in the
// bench. The sender works in random bursts, the receiver stalls on its own
// random pattern, and a watchdog ends the run if nothing moves for too long.
// ----------------------------------------------------------------------------
module tb;

    import fntsn_pkg::*;

    localparam int RANDOM_CHARS = 150;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 30;

    localparam byte_t BASE_REJECT_SET [16] = '{
        8'h22, 8'h2A, 8'h2B, 8'h2C, 8'h2E, 8'h2F, 8'h3A, 8'h3B,
        8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h5B, 8'h5C, 8'h5D, 8'h7C
    };

    typedef struct packed
    {
        byte_t sym;
        logic  ok;
        logic  tail;
    } sfn_item_t;

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  char_valid = 1'b0;
    logic  char_stall;
    byte_t name_char  = 8'h00;
    logic  last_char  = 1'b0;
    logic  sfn_valid;
    logic  sfn_stall  = 1'b0;
    byte_t short_byte;
    logic  name_valid;
    logic  last_byte;

    sfn_item_t sfn_expected [$];
    sfn_item_t sfn_want;
    int        error_count = 0;
    int        burst_left  = 0;
    int        chars_sent  = 0;
    int        stall_run   = 0;
    logic      stall_level = 1'b0;
    int        idle_cycles = 0;

    byte_t name_buf [SFN_LEN];
    pos_t  name_fill;
    logic  name_in_ext;
    logic  name_bad;

    file_name_to_short_name dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .name_char  (name_char),
        .last_char  (last_char),
        .sfn_valid  (sfn_valid),
        .sfn_stall  (sfn_stall),
        .short_byte (short_byte),
        .name_valid (name_valid),
        .last_byte  (last_byte)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic byte_t to_upper(input byte_t c);
        if (c >= LOWER_A && c <= LOWER_Z)
        begin
            return c - CASE_GAP;
        end
        return c;
    endfunction

    function automatic logic base_ok(input byte_t c);
        if (c <= PAD_CHAR)
        begin
            return 1'b0;
        end
        foreach (BASE_REJECT_SET[k])
        begin
            if (c == BASE_REJECT_SET[k])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic clear_name();
        foreach (name_buf[k])
        begin
            name_buf[k] = PAD_CHAR;
        end
        name_fill   = '0;
        name_in_ext = 1'b0;
        name_bad    = 1'b0;
    endtask

    task automatic fold_name_char(input byte_t c, input logic l);
        sfn_item_t item;
        if (!name_bad)
        begin
            if (!name_in_ext)
            begin
                if (c == DOT_CHAR)
                begin
                    name_in_ext = 1'b1;
                    name_fill   = BASE_END;
                end
                else if (name_fill >= BASE_END || !base_ok(c))
                begin
                    name_bad = 1'b1;
                end
                else
                begin
                    name_buf[name_fill] = to_upper(c);
                    name_fill           = name_fill + pos_t'(1);
                end
            end
            else if (name_fill >= SFN_END)
            begin
                name_bad = 1'b1;
            end
            else
            begin
                name_buf[name_fill] = to_upper(c);
                name_fill           = name_fill + pos_t'(1);
            end
        end
        if (l)
        begin
            for (int k = 0; k < SFN_LEN; k++)
            begin
                item.sym  = name_buf[k];
                item.ok   = ~name_bad;
                item.tail = (k == SFN_LEN - 1);
                sfn_expected.push_back(item);
            end
            clear_name();
        end
    endtask

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // hold valid across back-to-back items; drop it only for a gap
    task automatic send_char(input byte_t c, input logic l);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 6);
            end
        end
        burst_left--;
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid <= 1'b1;
        name_char  <= c;
        last_char  <= l;
        forever
        begin
            @(posedge clk);
            if (!char_stall)
            begin
                break;
            end
        end
        fold_name_char(c, l);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
        begin
            send_char(byte_t'(s[k]), k == s.len() - 1);
        end
    endtask

    task automatic drain_results();
        char_valid <= 1'b0;
        while (sfn_expected.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic byte_t pick_base_char();
        byte_t c;
        case ($urandom_range(0, 3))
            0:       c = byte_t'($urandom_range(8'h61, 8'h7A));
            1:       c = byte_t'($urandom_range(8'h41, 8'h5A));
            2:       c = byte_t'($urandom_range(8'h30, 8'h39));
            default: c = byte_t'($urandom_range(8'h21, 8'hFF));
        endcase
        while (!base_ok(c))
        begin
            c = byte_t'($urandom_range(8'h21, 8'hFF));
        end
        return c;
    endfunction

    task automatic test_single_bytes();
        send_text(".");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_case_and_dots();
        send_text("a..");
    endtask

    task automatic test_overlong_parts();
        send_text("zabcdefgh");
        send_text(".abcd");
    endtask

    task automatic test_ignore_after_reject();
        send_text("|x");
    endtask

    task automatic test_random_names();
        byte_t name [$];
        int    base_len;
        int    ext_len;
        int    random_sent;
        logic  paused;
        random_sent = 0;
        paused      = 1'b0;
        while (random_sent < RANDOM_CHARS)
        begin
            name.delete();
            if ($urandom_range(0, 4) != 0)
            begin
                base_len = $urandom_range(0, 8);
                for (int k = 0; k < base_len; k++)
                begin
                    name.push_back(pick_base_char());
                end
                if ($urandom_range(0, 3) != 0 || base_len == 0)
                begin
                    name.push_back(DOT_CHAR);
                    ext_len = $urandom_range(0, 3);
                    for (int k = 0; k < ext_len; k++)
                    begin
                        name.push_back(byte_t'($urandom_range(0, 255)));
                    end
                end
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        base_len = $urandom_range(9, 12);
                        for (int k = 0; k < base_len; k++)
                        begin
                            name.push_back(pick_base_char());
                        end
                    end
                    1:
                    begin
                        base_len = $urandom_range(0, 8);
                        for (int k = 0; k < base_len; k++)
                        begin
                            name.push_back(pick_base_char());
                        end
                        name.push_back(DOT_CHAR);
                        ext_len = $urandom_range(4, 6);
                        for (int k = 0; k < ext_len; k++)
                        begin
                            name.push_back(byte_t'($urandom_range(0, 255)));
                        end
                    end
                    default:
                    begin
                        ext_len = $urandom_range(1, 14);
                        for (int k = 0; k < ext_len; k++)
                        begin
                            if ($urandom_range(0, 3) == 0)
                            begin
                                name.push_back(DOT_CHAR);
                            end
                            else
                            begin
                                name.push_back(byte_t'($urandom_range(0, 255)));
                            end
                        end
                    end
                endcase
            end
            for (int k = 0; k < name.size(); k++)
            begin
                send_char(name[k], k == name.size() - 1);
            end
            random_sent += name.size();
            if (!paused && random_sent >= RANDOM_CHARS / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                stall_level = 1'b1;
                stall_run   = $urandom_range(1, 5);
            end
            else
            begin
                stall_level = 1'b0;
                stall_run   = $urandom_range(1, 25);
            end
        end
        stall_run--;
        sfn_stall <= stall_level;
    end

    always @(posedge clk)
    begin
        if (rst_n && sfn_valid && !sfn_stall)
        begin
            if (sfn_expected.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected item, byte %02h", short_byte));
            end
            else
            begin
                sfn_want = sfn_expected.pop_front();
                if (short_byte !== sfn_want.sym)
                begin
                    flag_mismatch($sformatf("short_byte %02h, want %02h",
                                            short_byte, sfn_want.sym));
                end
                if (name_valid !== sfn_want.ok)
                begin
                    flag_mismatch($sformatf("name_valid %b, want %b",
                                            name_valid, sfn_want.ok));
                end
                if (last_byte !== sfn_want.tail)
                begin
                    flag_mismatch($sformatf("last_byte %b, want %b",
                                            last_byte, sfn_want.tail));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && !char_stall) || (sfn_valid && !sfn_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        clear_name();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_bytes();
        test_case_and_dots();
        test_overlong_parts();
        test_ignore_after_reject();
        test_random_names();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        while (sfn_expected.size() != 0)
        begin
            flag_mismatch($sformatf("missing item, byte %02h", sfn_expected[0].sym));
            void'(sfn_expected.pop_front());
        end
        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
